/* rtl/sbmq_pkg.sv */
// ----------------------------------------------------------------------------
// sbmq_pkg
// Shared types and constants for the shared-buffer multi-queue block.
// ----------------------------------------------------------------------------
package sbmq_pkg;

	localparam int unsigned ENTRIES_DEF = 64;
	localparam int unsigned QUEUES_DEF  = 8;

	typedef enum logic {
		KIND_ENQ = 1'b0,
		KIND_DEQ = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		STAT_DONE    = 2'd0,
		STAT_NO_FREE = 2'd1,
		STAT_EMPTY   = 2'd2
	} status_t;

	typedef struct packed {
		kind_t              kind;
		logic [2:0]         queue_id;
		logic signed [31:0] value_in;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic signed [31:0] value_out;
		logic               queue_empty;
		logic               store_full;
	} rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture request, read queue pointers and free link
		logic deq_read;  // read link and value of the queue head
		logic commit;    // update state, load result register
	} ctrl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_deq;
		logic deq_ok;
		logic out_free;
	} dp_status_t;

endpackage

/* rtl/shared_buffer_multi_queue_top.sv */
// ----------------------------------------------------------------------------
// shared_buffer_multi_queue_top
// QUEUES FIFO queues sharing one store of ENTRIES entries, with the freed
// entries chained on a free list through the same link memory.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_ready/req): one operation per transfer, an
//   enqueue of req.value_in to req.queue_id or a dequeue from it.
//   rsp channel (rsp_valid/rsp_ready/rsp): exactly one result per request,
//   in order: status, dequeued value (zero otherwise), and the queue-empty
//   and store-full flags as they stand after the operation.
//   An enqueue or a refused dequeue commits from the exec state, a dequeue
//   that takes an entry from a further commit state. One operation is in
//   flight at a time, so a new request waits for the last commit; the
//   dequeue needs a state more because it reads the head pointer and then
//   the head entry's link, one registered memory read after the other.
//   A request is accepted while the previous result still waits in the
//   output register; if the receiver stalls, the next operation holds just
//   before its commit until the register frees up, and the block takes no
//   further request meanwhile.
//   Reset: all queues empty, free list runs 0..ENTRIES-1 in order. There is
//   no clearing pass; never-used entries are tracked by a fill count, so the
//   block takes requests as soon as reset is released.
// ----------------------------------------------------------------------------
module shared_buffer_multi_queue_top
	import sbmq_pkg::*;
#(
	parameter int unsigned ENTRIES = ENTRIES_DEF,
	parameter int unsigned QUEUES  = QUEUES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	ctrl_cmd_t  cmd;   // sequencer commands
	dp_status_t stat;  // datapath status back to the sequencer

	// sequencer: idle -> exec -> (dequeue that takes an entry only) commit
	sbmq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// memories, pointers and the result register
	sbmq_dp #(
		.ENTRIES (ENTRIES),
		.QUEUES  (QUEUES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

/* rtl/sbmq_ctrl.sv */
// ----------------------------------------------------------------------------
// sbmq_ctrl
// Sequencer: accepts a request, steps the datapath through its memory reads,
// and commits when the result register can take the result.
// ----------------------------------------------------------------------------
module sbmq_ctrl
	import sbmq_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	input  dp_status_t stat,
	output ctrl_cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE    = 3'b001,
		S_EXEC    = 3'b010,
		S_DCOMMIT = 3'b100
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		req_ready    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				if (stat.is_deq && stat.deq_ok) begin
					cmd.deq_read = 1'b1;
					state_d      = S_DCOMMIT;
				end else if (stat.out_free) begin
					// enqueue, or refused dequeue
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_DCOMMIT: begin
				if (stat.out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* rtl/sbmq_dp.sv */
// ----------------------------------------------------------------------------
// sbmq_dp
// Datapath: entry value and link memories, queue head/tail memories,
// free-list head, fresh-entry fill count and the result register.
// ----------------------------------------------------------------------------
module sbmq_dp
	import sbmq_pkg::*;
#(
	parameter int unsigned ENTRIES = ENTRIES_DEF,
	parameter int unsigned QUEUES  = QUEUES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  req_t       req,
	output rsp_t       rsp,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	input  ctrl_cmd_t  cmd,
	output dp_status_t stat
);

	localparam int unsigned AW  = $clog2(ENTRIES);
	localparam int unsigned LW  = $clog2(ENTRIES + 1);
	localparam int unsigned QIW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
	localparam int unsigned QXW = (QIW > 3) ? QIW : 3;
	localparam logic [LW-1:0] NIL = LW'(ENTRIES);

	// memories
	logic [LW-1:0]      link_mem  [ENTRIES];
	logic signed [31:0] value_mem [ENTRIES];
	logic [AW-1:0]      head_mem  [QUEUES];
	logic [AW-1:0]      tail_mem  [QUEUES];

	// registers
	req_t               item_q;
	logic               q_ok_q;
	logic [LW-1:0]      free_head_q;
	logic [LW-1:0]      fill_q;      // entries at or above this were never taken
	logic [QUEUES-1:0]  nonempty_q;
	logic [AW-1:0]      head_rd_q;
	logic [AW-1:0]      tail_rd_q;
	logic [LW-1:0]      link_rd_q;
	logic signed [31:0] value_rd_q;
	rsp_t               rsp_q;
	logic               rsp_valid_q;

	logic [QXW-1:0] qx_in, qx_item;
	logic [QIW-1:0] q_idx_in, q_idx;
	logic           q_ok_in;
	logic [AW-1:0]  fh_addr;
	logic           fh_ok, fh_fresh;
	logic [LW-1:0]  fill_inc, next_free_enq;
	logic           ne_cur, is_enq, enq_ok, deq_ok, last;
	logic           do_enq, do_deq;
	rsp_t           result;

	assign qx_in    = QXW'(req.queue_id);
	assign q_idx_in = qx_in[QIW-1:0];
	assign q_ok_in  = ({1'b0, qx_in} < (QXW + 1)'(QUEUES));
	assign qx_item  = QXW'(item_q.queue_id);
	assign q_idx    = qx_item[QIW-1:0];

	assign fh_addr       = free_head_q[AW-1:0];
	assign fh_ok         = (free_head_q < NIL);
	assign fh_fresh      = (free_head_q == fill_q);
	assign fill_inc      = LW'(fill_q + 1'b1);
	assign next_free_enq = fh_fresh ? fill_inc : link_rd_q;

	assign ne_cur = q_ok_q && nonempty_q[q_idx];
	assign is_enq = (item_q.kind == KIND_ENQ);
	assign enq_ok = q_ok_q && fh_ok;
	assign deq_ok = ne_cur;
	assign last   = (head_rd_q == tail_rd_q);
	assign do_enq = cmd.commit && is_enq && enq_ok;
	assign do_deq = cmd.commit && !is_enq && deq_ok;

	always_comb begin
		result = '0;
		if (is_enq) begin
			result.status      = enq_ok ? STAT_DONE : STAT_NO_FREE;
			result.queue_empty = enq_ok ? 1'b0 : !ne_cur;
			result.store_full  = enq_ok ? (next_free_enq == NIL) : !fh_ok;
		end else begin
			result.status      = deq_ok ? STAT_DONE : STAT_EMPTY;
			result.value_out   = deq_ok ? value_rd_q : 32'sd0;
			result.queue_empty = deq_ok ? last : 1'b1;
			result.store_full  = deq_ok ? 1'b0 : !fh_ok;
		end
	end

	// request capture and memory read ports
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q    <= req;
			q_ok_q    <= q_ok_in;
			head_rd_q <= head_mem[q_idx_in];
			tail_rd_q <= tail_mem[q_idx_in];
			link_rd_q <= link_mem[fh_addr];
		end else if (cmd.deq_read) begin
			link_rd_q  <= link_mem[head_rd_q];
			value_rd_q <= value_mem[head_rd_q];
		end
	end

	// memory write ports
	always_ff @(posedge clk) begin
		if (do_enq) begin
			value_mem[fh_addr] <= item_q.value_in;
			tail_mem[q_idx]    <= fh_addr;
			if (ne_cur) begin
				link_mem[tail_rd_q] <= free_head_q;
			end else begin
				head_mem[q_idx] <= fh_addr;
			end
		end else if (do_deq) begin
			head_mem[q_idx]     <= link_rd_q[AW-1:0];
			link_mem[head_rd_q] <= free_head_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_head_q <= '0;
			fill_q      <= '0;
			nonempty_q  <= '0;
		end else if (do_enq) begin
			free_head_q       <= next_free_enq;
			nonempty_q[q_idx] <= 1'b1;
			if (fh_fresh) begin
				fill_q <= fill_inc;
			end
		end else if (do_deq) begin
			free_head_q <= LW'(head_rd_q);
			if (last) begin
				nonempty_q[q_idx] <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			rsp_q <= result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

	assign stat.is_deq   = !is_enq;
	assign stat.deq_ok   = deq_ok;
	assign stat.out_free = !rsp_valid_q || rsp_ready;

endmodule

/* test/shared_buffer_multi_queue_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shared_buffer_multi_queue_checker
// Watches both channels of the shared-buffer multi-queue block. It keeps its
// own copy of the linked entry store, works out the outcome of every accepted
// operation and compares each returned result with the oldest outcome due.
// ----------------------------------------------------------------------------
module shared_buffer_multi_queue_checker
	import sbmq_pkg::*;
#(
	parameter int unsigned ENTRIES = ENTRIES_DEF,
	parameter int unsigned QUEUES  = QUEUES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_ready,
	input  req_t req,
	input  logic rsp_valid,
	input  logic rsp_ready,
	input  rsp_t rsp,
	output int   errors,
	output int   pending
);

	localparam int unsigned AW = $clog2(ENTRIES);
	localparam int unsigned LW = $clog2(ENTRIES + 1);
	localparam logic [LW-1:0] NIL = LW'(ENTRIES);

	logic [31:0]   slot_value [ENTRIES];
	logic [LW-1:0] slot_link  [ENTRIES];
	logic [LW-1:0] q_head     [QUEUES];
	logic [LW-1:0] q_tail     [QUEUES];
	logic [LW-1:0] free_top;

	rsp_t outcomes_due [$];
	rsp_t due;

	// Applies one operation to the shadow store and returns its result.
	function automatic rsp_t apply_op(req_t r);
		rsp_t o;
		logic [LW-1:0] slot;
		logic q_ok;
		o = '0;
		o.status = STAT_DONE;
		q_ok = (r.queue_id < QUEUES);
		if (r.kind == KIND_ENQ) begin
			if (!q_ok || free_top >= NIL) begin
				o.status = STAT_NO_FREE;
			end else begin
				slot = free_top;
				free_top = slot_link[slot[AW-1:0]];
				if (q_head[r.queue_id] >= NIL) begin
					q_head[r.queue_id] = slot;
				end else begin
					slot_link[q_tail[r.queue_id][AW-1:0]] = slot;
				end
				slot_link[slot[AW-1:0]] = NIL;
				q_tail[r.queue_id] = slot;
				slot_value[slot[AW-1:0]] = r.value_in;
			end
		end else begin
			if (!q_ok || q_head[r.queue_id] >= NIL) begin
				o.status = STAT_EMPTY;
			end else begin
				slot = q_head[r.queue_id];
				q_head[r.queue_id] = slot_link[slot[AW-1:0]];
				slot_link[slot[AW-1:0]] = free_top;
				free_top = slot;
				o.value_out = slot_value[slot[AW-1:0]];
			end
		end
		o.queue_empty = !q_ok || (q_head[r.queue_id] >= NIL);
		o.store_full  = (free_top >= NIL);
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				slot_value[i] = '0;
				slot_link[i]  = (i + 1 < ENTRIES) ? LW'(i + 1) : NIL;
			end
			for (int i = 0; i < QUEUES; i++) begin
				q_head[i] = NIL;
				q_tail[i] = NIL;
			end
			free_top = '0;
			outcomes_due.delete();
			errors  = 0;
			pending = 0;
		end else begin
			if (req_valid && req_ready)
				outcomes_due.push_back(apply_op(req));
			if (rsp_valid && rsp_ready) begin
				if (outcomes_due.size() == 0) begin
					$display("%0t: result with none due: status %0d value %0d", $time,
						rsp.status, rsp.value_out);
					errors++;
				end else begin
					due = outcomes_due.pop_front();
					if (rsp.status !== due.status) begin
						$display("%0t: status expected %0d got %0d", $time,
							due.status, rsp.status);
						errors++;
					end
					if (rsp.value_out !== due.value_out) begin
						$display("%0t: value_out expected %0d got %0d", $time,
							due.value_out, rsp.value_out);
						errors++;
					end
					if (rsp.queue_empty !== due.queue_empty) begin
						$display("%0t: queue_empty expected %b got %b", $time,
							due.queue_empty, rsp.queue_empty);
						errors++;
					end
					if (rsp.store_full !== due.store_full) begin
						$display("%0t: store_full expected %b got %b", $time,
							due.store_full, rsp.store_full);
						errors++;
					end
				end
			end
			pending = outcomes_due.size();
		end
	end

endmodule

/* test/shared_buffer_multi_queue_top_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shared_buffer_multi_queue_top_test
// Drives enqueue and dequeue transfers into the shared-buffer multi-queue
// block: a short directed run over value extremes and empty-queue cases, then
// random phases that alternately fill and drain the store, with bursty
// requests and a stalling receiver. The checker predicts and compares.
// ----------------------------------------------------------------------------
module shared_buffer_multi_queue_top_test;
	import sbmq_pkg::*;

	localparam int LIMIT      = 500000; // cycles before giving up
	localparam int PHASES     = 10;
	localparam int PHASE_OPS  = 125;    // random operations per phase

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	int errors;
	int pending;
	int cycles = 0;

	// Share of enqueues per phase, in percent: high phases push the store to
	// full so enqueues get refused, low phases drain queues to empty.
	int unsigned enq_pct [PHASES] = '{90, 50, 15, 95, 10, 60, 85, 30, 98, 5};

	shared_buffer_multi_queue_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	shared_buffer_multi_queue_checker i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.errors    (errors),
		.pending   (pending)
	);

	always #5 clk = ~clk;

	// Watchdog.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Receiver: the stall style is redrawn at random on a period counted by rx_cycle. Style 0 never
	// stalls, style 1 stalls often and briefly, style 2 rarely but long.
	int unsigned stall_left = 0;
	int unsigned stall_style = 0;
	int unsigned rx_cycle = 0;
	always @(negedge clk) begin
		rx_cycle++;
		if (rx_cycle % 200 == 0)
			stall_style = $urandom_range(2, 0);
		if (stall_left > 0) begin
			stall_left--;
			rsp_ready <= 1'b0;
		end else if (stall_style == 1 && $urandom_range(2, 0) == 0) begin
			stall_left = $urandom_range(2, 0);
			rsp_ready <= 1'b0;
		end else if (stall_style == 2 && $urandom_range(7, 0) == 0) begin
			stall_left = $urandom_range(19, 4);
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	// Presents one operation and holds it until the transfer. Entered and
	// left at a falling edge; valid stays high on return so back-to-back
	// operations need no extra assignment.
	task automatic send_op(kind_t k, logic [2:0] qid, logic signed [31:0] val);
		req_valid <= 1'b1;
		req <= '{kind: k, queue_id: qid, value_in: val};
		do @(posedge clk); while (!req_ready);
		@(negedge clk);
	endtask

	initial begin
		int unsigned burst_left;
		logic [31:0] val;
		logic [2:0] qid;
		kind_t k;

		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: dequeue from an empty queue (payload ignored), value
		// extremes through the lowest and highest queue, FIFO order, and a
		// dequeue carrying a nonzero value_in.
		send_op(KIND_DEQ, 3'd0, 32'h7fffffff);
		send_op(KIND_ENQ, 3'd0, 32'h7fffffff);
		send_op(KIND_ENQ, 3'd0, 32'h80000000);
		send_op(KIND_ENQ, 3'd7, 32'h00000000);
		send_op(KIND_ENQ, 3'd7, 32'hffffffff);
		send_op(KIND_ENQ, 3'd5, 32'haaaaaaaa);
		send_op(KIND_ENQ, 3'd2, 32'h55555555);
		send_op(KIND_DEQ, 3'd0, 32'h0);
		send_op(KIND_DEQ, 3'd0, 32'h0);
		send_op(KIND_DEQ, 3'd0, 32'h0);
		send_op(KIND_DEQ, 3'd7, 32'h0);
		send_op(KIND_DEQ, 3'd7, 32'h0);
		send_op(KIND_DEQ, 3'd7, 32'h0);
		send_op(KIND_DEQ, 3'd5, 32'h0);
		send_op(KIND_DEQ, 3'd2, 32'hffffffff);
		send_op(KIND_ENQ, 3'd3, 32'd1);
		send_op(KIND_ENQ, 3'd3, 32'd2);
		send_op(KIND_DEQ, 3'd3, 32'h0);
		send_op(KIND_ENQ, 3'd3, 32'd3);
		send_op(KIND_DEQ, 3'd3, 32'h0);
		send_op(KIND_DEQ, 3'd3, 32'h0);

		// Random phases. The store carries over between phases, so fill
		// phases reach a full store and drain phases hit empty queues.
		burst_left = 0;
		for (int p = 0; p < PHASES; p++) begin
			for (int n = 0; n < PHASE_OPS; n++) begin
				// Sender bursts; every fourth phase runs without gaps.
				if (burst_left == 0) begin
					burst_left = $urandom_range(24, 1);
					if (p % 4 != 2) begin
						req_valid <= 1'b0;
						repeat ($urandom_range(8, 1)) @(negedge clk);
					end
				end
				burst_left--;
				k = ($urandom_range(99, 0) < enq_pct[p]) ? KIND_ENQ : KIND_DEQ;
				// Some phases crowd two queues so their chains grow long.
				qid = (p % 3 == 1) ? 3'($urandom_range(1, 0)) : 3'($urandom_range(7, 0));
				case ($urandom_range(7, 0))
					0: val = 32'h80000000;
					1: val = 32'h7fffffff;
					2: val = 32'hffffffff;
					3: val = 32'h00000000;
					default: val = $urandom;
				endcase
				send_op(k, qid, val);
			end
			// Every other phase boundary the sender holds off until the block
			// has returned everything it owes.
			if (p % 2 == 1) begin
				req_valid <= 1'b0;
				do @(negedge clk); while (pending != 0);
				burst_left = 0;
			end
		end

		req_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

/* shared_buffer_multi_queue_top.f */
rtl/sbmq_pkg.sv
rtl/sbmq_ctrl.sv
rtl/sbmq_dp.sv
rtl/shared_buffer_multi_queue_top.sv
test/shared_buffer_multi_queue_checker.sv
test/shared_buffer_multi_queue_top_test.sv
